>>> rtl/integer_reduction_alu_top_defines.svh
// ----------------------------------------------------------------------------
// Integer reduction ALU assertion macros
// Concurrent assertion shorthands used by the bound checker file.
// ----------------------------------------------------------------------------
`ifndef INTEGER_REDUCTION_ALU_TOP_DEFINES_SVH
`define INTEGER_REDUCTION_ALU_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU package
// Item types, operation and status codes, and shared control types.
// ----------------------------------------------------------------------------
package ira_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Raw operation codes as they arrive on the input channel.
    localparam logic [3:0] OPC_ADD  = 4'd0;
    localparam logic [3:0] OPC_SUB  = 4'd1;
    localparam logic [3:0] OPC_MUL  = 4'd2;
    localparam logic [3:0] OPC_DIV  = 4'd3;
    localparam logic [3:0] OPC_REM  = 4'd4;
    localparam logic [3:0] OPC_MIN  = 4'd5;
    localparam logic [3:0] OPC_MAX  = 4'd6;
    localparam logic [3:0] OPC_AND  = 4'd7;
    localparam logic [3:0] OPC_OR   = 4'd8;
    localparam logic [3:0] OPC_XOR  = 4'd9;
    localparam logic [3:0] OPC_EXPT = 4'd10;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_MIN,
        OP_MAX, OP_AND, OP_OR, OP_XOR, OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_BADOP   = 2'd2
    } t_status;

    typedef enum logic {
        MODE_MUL,
        MODE_DIV
    } t_iter_mode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BUSY,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [3:0]  op_code;
        logic [31:0] operand;
        logic        first_item;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } t_out_item;

    // Classified command passed from the front end to the execution side.
    typedef struct packed {
        logic open_run;
        logic last;
        t_op  op;
    } t_cmd;

    function automatic t_op op_decode(input logic [3:0] code);
        t_op op;
        case (code)
            OPC_ADD: op = OP_ADD;
            OPC_SUB: op = OP_SUB;
            OPC_MUL: op = OP_MUL;
            OPC_DIV: op = OP_DIV;
            OPC_REM: op = OP_REM;
            OPC_MIN: op = OP_MIN;
            OPC_MAX: op = OP_MAX;
            OPC_AND: op = OP_AND;
            OPC_OR:  op = OP_OR;
            OPC_XOR: op = OP_XOR;
            default: op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

>>> rtl/ira_queue.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU command queue
// Small register-based FIFO between the front end and the execution side.
// ----------------------------------------------------------------------------
module ira_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ira_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

>>> rtl/ira_iter.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU iterative unit
// Radix-2 shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ira_iter #(
    parameter int DATA_WIDTH = ira_pkg::DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  ira_pkg::t_iter_mode     i_mode,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    output logic                    o_done,
    output logic [DATA_WIDTH-1:0]   o_low,
    output logic [DATA_WIDTH-1:0]   o_quotient
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic                r_busy, r_done;
    logic [CNT_W-1:0]    r_cnt;
    ira_pkg::t_iter_mode r_mode;
    // Multiply: r_x multiplier, r_y product, r_z shifted multiplicand.
    // Divide:   r_x dividend turning into quotient, r_y remainder, r_z divisor.
    logic [W-1:0]        r_x, r_y, r_z;
    logic [W:0]          rem_sh, diff;

    assign rem_sh     = {r_y, r_x[W-1]};
    assign diff       = rem_sh - {1'b0, r_z};
    assign o_done     = r_done;
    assign o_low      = r_y;
    assign o_quotient = r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_y    <= '0;
            if (i_mode == ira_pkg::MODE_MUL) begin
                r_x <= i_b;
                r_z <= i_a;
            end else begin
                r_x <= i_a;
                r_z <= i_b;
            end
        end else if (r_busy) begin
            if (r_mode == ira_pkg::MODE_MUL) begin
                r_y <= r_y + (r_x[0] ? r_z : '0);
                r_x <= r_x >> 1;
                r_z <= r_z << 1;
            end else begin
                r_y <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
                r_x <= {r_x[W-2:0], ~diff[W]};
            end
        end
    end

endmodule

>>> rtl/ira_front.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU front end
// Accepts items, tracks open runs and classifies each item into a command.
// ----------------------------------------------------------------------------
module ira_front #(
    parameter int DATA_WIDTH = ira_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ira_pkg::t_in_item     i_in_item,
    input  logic                  i_full,
    output logic                  o_push,
    output ira_pkg::t_cmd         o_push_cmd,
    output logic [DATA_WIDTH-1:0] o_push_operand
);

    logic         r_run_open, n_run_open;
    ira_pkg::t_op r_op, n_op;
    logic         accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    // Operands are sign-extended or truncated to the datapath width.
    generate
        if (DATA_WIDTH > 32) begin : g_ext
            assign o_push_operand = {{(DATA_WIDTH - 32){i_in_item.operand[31]}},
                                     i_in_item.operand};
        end else if (DATA_WIDTH == 32) begin : g_same
            assign o_push_operand = i_in_item.operand;
        end else begin : g_trunc
            assign o_push_operand = i_in_item.operand[DATA_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        n_run_open          = r_run_open;
        n_op                = r_op;
        o_push              = 1'b0;
        o_push_cmd.open_run = i_in_item.first_item;
        o_push_cmd.last     = i_in_item.last_item;
        o_push_cmd.op       = r_op;
        if (i_in_item.first_item) begin
            o_push_cmd.op = ira_pkg::op_decode(i_in_item.op_code);
        end
        if (accept) begin
            if (i_in_item.first_item) begin
                o_push     = 1'b1;
                n_op       = o_push_cmd.op;
                n_run_open = !i_in_item.last_item;
            end else if (r_run_open) begin
                o_push     = 1'b1;
                n_run_open = !i_in_item.last_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
            r_op       <= ira_pkg::OP_ADD;
        end else begin
            r_run_open <= n_run_open;
            r_op       <= n_op;
        end
    end

endmodule

>>> rtl/ira_back.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU execution side
// Folds queued commands into the accumulator and registers the results.
// ----------------------------------------------------------------------------
module ira_back #(
    parameter int DATA_WIDTH = ira_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  ira_pkg::t_cmd         i_head_cmd,
    input  logic [DATA_WIDTH-1:0] i_head_operand,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ira_pkg::t_out_item    o_out_item
);

    localparam int W = DATA_WIDTH;

    ira_pkg::t_back_state r_state, n_state;
    logic [W-1:0]         r_acc, n_acc;
    ira_pkg::t_status     r_err, n_err;
    logic                 r_last, n_last;
    ira_pkg::t_op         r_op, n_op;
    logic                 r_neg_q, n_neg_q;
    logic                 r_neg_r, n_neg_r;
    logic                 r_out_valid, n_out_valid;
    ira_pkg::t_out_item   r_out_item, n_out_item;

    logic                 it_start, it_done;
    ira_pkg::t_iter_mode  it_mode;
    logic [W-1:0]         it_a, it_b, it_low, it_quo;
    logic [W-1:0]         opnd, mag_a, mag_b;
    logic [31:0]          acc_ext;
    logic                 out_free;

    assign opnd     = i_head_operand;
    assign mag_a    = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;
    assign mag_b    = opnd[W-1] ? (W'(0) - opnd) : opnd;
    assign out_free = !r_out_valid || i_out_ready;

    generate
        if (W >= 32) begin : g_out_trunc
            assign acc_ext = r_acc[31:0];
        end else begin : g_out_ext
            assign acc_ext = {{(32 - W){r_acc[W-1]}}, r_acc};
        end
    endgenerate

    ira_iter #(
        .DATA_WIDTH(W)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (it_start),
        .i_mode     (it_mode),
        .i_a        (it_a),
        .i_b        (it_b),
        .o_done     (it_done),
        .o_low      (it_low),
        .o_quotient (it_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_err       = r_err;
        n_last      = r_last;
        n_op        = r_op;
        n_neg_q     = r_neg_q;
        n_neg_r     = r_neg_r;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_pop       = 1'b0;
        it_start    = 1'b0;
        it_mode     = ira_pkg::MODE_MUL;
        it_a        = r_acc;
        it_b        = opnd;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ira_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_last = i_head_cmd.last;
                    n_op   = i_head_cmd.op;
                    if (i_head_cmd.open_run) begin
                        n_acc = opnd;
                        n_err = ira_pkg::ST_OK;
                        if (i_head_cmd.last) begin
                            if (i_head_cmd.op == ira_pkg::OP_SUB) begin
                                n_acc = W'(0) - opnd;
                            end else if (i_head_cmd.op == ira_pkg::OP_DIV) begin
                                // A lone divide gives the integer reciprocal.
                                if (opnd == '0) begin
                                    n_err = ira_pkg::ST_DIVZERO;
                                end else if (opnd != W'(1) && opnd != '1) begin
                                    n_acc = '0;
                                end
                            end
                        end
                    end else if (r_err == ira_pkg::ST_OK) begin
                        case (i_head_cmd.op)
                            ira_pkg::OP_ADD: n_acc = r_acc + opnd;
                            ira_pkg::OP_SUB: n_acc = r_acc - opnd;
                            ira_pkg::OP_AND: n_acc = r_acc & opnd;
                            ira_pkg::OP_OR:  n_acc = r_acc | opnd;
                            ira_pkg::OP_XOR: n_acc = r_acc ^ opnd;
                            ira_pkg::OP_MIN: begin
                                if ($signed(opnd) < $signed(r_acc)) begin
                                    n_acc = opnd;
                                end
                            end
                            ira_pkg::OP_MAX: begin
                                if ($signed(r_acc) < $signed(opnd)) begin
                                    n_acc = opnd;
                                end
                            end
                            ira_pkg::OP_MUL: begin
                                it_start = 1'b1;
                            end
                            ira_pkg::OP_DIV, ira_pkg::OP_REM: begin
                                if (opnd == '0) begin
                                    n_err = ira_pkg::ST_DIVZERO;
                                end else begin
                                    it_start = 1'b1;
                                    it_mode  = ira_pkg::MODE_DIV;
                                    it_a     = mag_a;
                                    it_b     = mag_b;
                                    n_neg_q  = r_acc[W-1] ^ opnd[W-1];
                                    n_neg_r  = r_acc[W-1];
                                end
                            end
                            default: n_err = ira_pkg::ST_BADOP;
                        endcase
                    end
                    if (it_start) begin
                        n_state = ira_pkg::BK_BUSY;
                    end else if (i_head_cmd.last) begin
                        n_state = ira_pkg::BK_EMIT;
                    end
                end
            end
            ira_pkg::BK_BUSY: begin
                if (it_done) begin
                    case (r_op)
                        ira_pkg::OP_DIV: n_acc = r_neg_q ? (W'(0) - it_quo) : it_quo;
                        ira_pkg::OP_REM: n_acc = r_neg_r ? (W'(0) - it_low) : it_low;
                        default:         n_acc = it_low;
                    endcase
                    n_state = r_last ? ira_pkg::BK_EMIT : ira_pkg::BK_IDLE;
                end
            end
            ira_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_item.status       = r_err;
                    n_out_item.result_value = (r_err == ira_pkg::ST_OK) ? acc_ext : '0;
                    n_state                 = ira_pkg::BK_IDLE;
                end
            end
            default: n_state = ira_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ira_pkg::BK_IDLE;
            r_acc       <= '0;
            r_err       <= ira_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_op       <= n_op;
        r_neg_q    <= n_neg_q;
        r_neg_r    <= n_neg_r;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/integer_reduction_alu_top.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU
// Folds runs of signed operands under one latched operation.
// ----------------------------------------------------------------------------
// Usage: items enter on the valid/ready input channel; each item carries an
// op code, an operand and first/last marks. A first item opens a run and
// latches the operation; the item marked last closes it and produces one
// result item on the valid/ready output channel. Items that arrive with no
// run open are dropped without a result.
// The front end accepts an item in every cycle while the command queue has
// room, so the sender sees stalls only when the queue fills. The execution
// side takes one command a cycle for add, subtract, min, max and the logic
// operations; multiply, divide and remainder folds run on a bit-serial unit,
// which takes no further command until it is done. A closing item then
// passes through an emit state that loads the output register.
// When the receiver stalls, the result waits in the output register while
// the queue keeps filling; execution waits only when a second result is due.
// A synchronous active-low reset empties the queue, closes any run, clears
// the accumulator and error code, and drops a pending result.
// ----------------------------------------------------------------------------
module integer_reduction_alu_top #(
    parameter int DATA_WIDTH  = ira_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ira_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ira_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ira_pkg::t_out_item o_out_item
);

    localparam int CMD_W = $bits(ira_pkg::t_cmd);
    localparam int Q_W   = CMD_W + DATA_WIDTH;

    logic                  push, pop, full, empty;
    ira_pkg::t_cmd         push_cmd, head_cmd;
    logic [DATA_WIDTH-1:0] push_operand, head_operand;
    logic [Q_W-1:0]        q_wr_data, q_rd_data;

    // The front end classifies items and drops those outside a run.
    ira_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_full         (full),
        .o_push         (push),
        .o_push_cmd     (push_cmd),
        .o_push_operand (push_operand)
    );

    // Each queue entry holds the command fields above the operand.
    assign q_wr_data    = {push_cmd, push_operand};
    assign head_cmd     = q_rd_data[DATA_WIDTH +: CMD_W];
    assign head_operand = q_rd_data[DATA_WIDTH-1:0];

    ira_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (q_wr_data),
        .o_full    (full),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rd_data (q_rd_data)
    );

    // The execution side owns the accumulator, the error code and the
    // output register.
    ira_back #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head_cmd     (head_cmd),
        .i_head_operand (head_operand),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

endmodule

>>> rtl/ira_checker.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_reduction_alu_top_defines.svh"

module ira_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ira_pkg::t_out_item i_out_item
);

    // A stalled result stays put until it is taken.
    `IRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item), "result item changed while stalled")

    // Any error status comes with a zero value.
    `IRA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_item.status != ira_pkg::ST_OK, i_out_item.result_value == 32'd0, "error result carries a nonzero value")

    // The unused status code never leaves the block.
    `IRA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid, i_out_item.status <= ira_pkg::ST_BADOP, "result status uses the reserved code")

endmodule

bind integer_reduction_alu_top ira_checker u_ira_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

>>> tb/ira_result_checker.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU result checker
// Watches both channels, folds each accepted item into a private copy of the
// run state, and compares every result item with the oldest expected one.
// ----------------------------------------------------------------------------
module ira_result_checker
    import ira_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_pending,
    output int        o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    // Private copy of the run state.
    logic [31:0] run_total;
    logic [3:0]  run_op;
    t_status     run_status;
    logic        run_active;

    t_out_item   awaited_results[$];

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // Applies one further operand of the run to the running total.
    function automatic void fold_operand(input logic [31:0] b);
        logic [31:0] a;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] quo;
        logic [31:0] rmd;
        a = run_total;
        case (run_op)
            OPC_ADD: a = a + b;
            OPC_SUB: a = a - b;
            OPC_MUL: a = a * b;
            OPC_DIV, OPC_REM: begin
                if (b == 32'd0) begin
                    run_status = ST_DIVZERO;
                    return;
                end
                // Divide magnitudes, then restore signs so that the quotient
                // truncates toward zero and the remainder follows the dividend.
                mag_a = a[31] ? 32'd0 - a : a;
                mag_b = b[31] ? 32'd0 - b : b;
                quo   = mag_a / mag_b;
                rmd   = mag_a % mag_b;
                if (a[31] ^ b[31]) quo = 32'd0 - quo;
                if (a[31]) rmd = 32'd0 - rmd;
                a = (run_op == OPC_DIV) ? quo : rmd;
            end
            OPC_MIN: if ($signed(b) < $signed(a)) a = b;
            OPC_MAX: if ($signed(a) < $signed(b)) a = b;
            OPC_AND: a = a & b;
            OPC_OR:  a = a | b;
            OPC_XOR: a = a ^ b;
            default: begin
                run_status = ST_BADOP;
                return;
            end
        endcase
        run_total = a;
    endfunction

    task automatic predict_reduction(input t_in_item it);
        t_out_item res;
        if (it.first_item) begin
            run_op     = it.op_code;
            run_total  = it.operand;
            run_status = ST_OK;
            run_active = 1'b1;
            if (it.last_item) begin
                // A lone operand is negated for subtract and reciprocated for divide.
                if (it.op_code == OPC_SUB) begin
                    run_total = 32'd0 - it.operand;
                end else if (it.op_code == OPC_DIV) begin
                    if (it.operand == 32'd0) begin
                        run_status = ST_DIVZERO;
                    end else if (it.operand != 32'd1 && it.operand != '1) begin
                        run_total = 32'd0;
                    end
                end
            end
        end else begin
            if (!run_active) return;
            if (run_status == ST_OK) fold_operand(it.operand);
        end
        if (it.last_item) begin
            run_active       = 1'b0;
            res.result_value = (run_status == ST_OK) ? run_total : 32'd0;
            res.status       = run_status;
            awaited_results.push_back(res);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %h / status %0d with none expected",
                                      got.result_value, got.status));
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_value !== want.result_value) begin
            report_mismatch($sformatf("result_value %h, expected %h",
                                      got.result_value, want.result_value));
        end
        if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_total    = 32'd0;
            run_op       = OPC_ADD;
            run_status   = ST_OK;
            run_active   = 1'b0;
            o_mismatches = 0;
            awaited_results.delete();
        end else begin
            // A result can never stem from an item accepted at the same edge.
            if (i_out_valid && i_out_ready) check_result(i_out_item);
            if (i_in_valid && i_in_ready) predict_reduction(i_in_item);
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Integer reduction ALU testbench
// Drives directed and random operand runs with random idling on both sides;
// a separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import ira_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The slowest correct run is roughly 2000 items plus receiver stalls; the
    // limit leaves several times the cycles that such a run takes.
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int PHASE_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int        pending_cnt;
    int        mismatch_cnt;

    // Percent chances of an idle cycle on the sending and receiving sides.
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;

    // Number of random-run items sent; orphans are not counted.
    int        items_sent = 0;
    // Whether the stream sent so far leaves a run open.
    logic      run_is_open = 1'b0;
    int        cycle_cnt = 0;

    integer_reduction_alu_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    ira_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending_cnt),
        .o_mismatches (mismatch_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random, one decision per cycle.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hang or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Operand mix: extremes and small values often, otherwise full-range random.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(11))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6, 7: return 32'($urandom_range(40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    // Sends one item. The task is entered and left at a rising edge. An idle
    // gap, when drawn, lowers valid first; otherwise valid simply stays high
    // from the previous item so it is never dropped and raised in one step.
    task automatic send_item(input logic [3:0] op, input logic [31:0] opnd,
                             input logic first, input logic last);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        in_valid           <= 1'b1;
        in_item.op_code    <= op;
        in_item.operand    <= opnd;
        in_item.first_item <= first;
        in_item.last_item  <= last;
        do @(posedge i_clk); while (!in_ready);
        if (first) run_is_open = 1'b1;
        if (last) run_is_open = 1'b0;
    endtask

    // A two-operand run: the first operand opens it, the second closes it.
    task automatic send_pair(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        send_item(op, a, 1'b1, 1'b0);
        send_item(op, b, 1'b0, 1'b1);
    endtask

    // The sender holds off until every expected result has come back. The
    // count is read at the falling edge, away from the checker's update.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_cnt != 0);
        @(posedge i_clk);
    endtask

    // One random run, occasionally preceded by an orphan item (ignored by the
    // block) or left without its closing item so the next run replaces it.
    task automatic send_random_run();
        logic [3:0] op;
        int         len;
        logic       broken;
        if (!run_is_open && $urandom_range(19) == 0) begin
            send_item(4'($urandom), rand_operand(), 1'b0, 1'($urandom));
        end
        op     = ($urandom_range(11) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(9));
        len    = $urandom_range(1, 6);
        broken = ($urandom_range(12) == 0);
        for (int k = 0; k < len; k++) begin
            // The op code of a non-first item is ignored, so it is left random.
            send_item((k == 0) ? op : 4'($urandom), rand_operand(), k == 0,
                      !broken && k == len - 1);
            items_sent++;
        end
    endtask

    initial begin
        int target;
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase settings also cover the directed part.
        send_gap_pct   = 22;
        recv_stall_pct = 54;

        // Lone operands: negation of the most negative value wraps to itself,
        // lone divides give a status or a truncated reciprocal, and a lone
        // exponent passes its operand through.
        send_item(OPC_SUB,  32'h8000_0000, 1'b1, 1'b1);
        send_item(OPC_DIV,  32'd0,         1'b1, 1'b1);
        send_item(OPC_DIV,  32'd1,         1'b1, 1'b1);
        send_item(OPC_DIV,  '1,            1'b1, 1'b1);
        send_item(OPC_DIV,  32'd7,         1'b1, 1'b1);
        send_item(OPC_EXPT, 32'd3,         1'b1, 1'b1);

        // Wrap at the top of the range and the most negative value divided by
        // minus one, for both the quotient and the remainder.
        send_pair(OPC_ADD, 32'h7FFF_FFFF, 32'd1);
        send_pair(OPC_DIV, 32'h8000_0000, '1);
        send_pair(OPC_REM, 32'h8000_0000, '1);

        // A zero divisor sets the error and the following operand is ignored.
        send_item(OPC_DIV, 32'd100, 1'b1, 1'b0);
        send_item(OPC_DIV, 32'd0,   1'b0, 1'b0);
        send_item(OPC_DIV, 32'd5,   1'b0, 1'b1);

        // Exponent on integers reports a bad operation.
        send_pair(OPC_EXPT, 32'd2, 32'd3);

        // An item with no run open gives no result even when marked last.
        send_item(OPC_ADD, 32'd9, 1'b0, 1'b1);

        // A first item during an open run drops the old run.
        send_item(OPC_ADD, 32'd1, 1'b1, 1'b0);
        send_pair(OPC_MUL, 32'hFFFF_FFFD, 32'h7FFF_FFFF);

        // The remaining operations with mixed signs.
        send_pair(OPC_SUB, 32'd10,        32'd23);
        send_pair(OPC_REM, 32'hFFFF_FFF9, 32'd2);
        send_pair(OPC_MIN, 32'd5,         32'hFFFF_FFF9);
        send_pair(OPC_MAX, 32'h8000_0000, 32'd3);
        send_pair(OPC_AND, '1,            32'h0F0F_0F0F);
        send_pair(OPC_OR,  32'd0,         32'h8000_0000);
        send_pair(OPC_XOR, '1,            32'h1234_5678);

        // Random runs in three phases of idling: sender light and receiver
        // heavy, then the reverse, then no idling at all. Between phases the
        // sender waits until every expected result is back.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 22;
                    recv_stall_pct = 54;
                end
                1: begin
                    send_gap_pct   = 54;
                    recv_stall_pct = 22;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_run();
            if (ph < 2) drain_results();
        end

        // Wait for the last results, then give the block time to show any
        // stray result before the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
